FILE: src/cst_pkg.sv
// Shared types, constants and character-class functions of the character stream tokenizer.
`default_nettype none
package cst_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [1:0] REG_SKIP_WS  = 2'd0;
	localparam logic [1:0] REG_STR_MODE = 2'd1;
	localparam logic [1:0] REG_NUM_MODE = 2'd2;

	localparam logic [1:0] KIND_WORD = 2'd0;
	localparam logic [1:0] KIND_NUM  = 2'd1;
	localparam logic [1:0] KIND_STR  = 2'd2;
	localparam logic [1:0] KIND_CHAR = 2'd3;

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_EXP    = 8'h45;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_WORD = 4'b0010,
		MODE_NUM  = 4'b0100,
		MODE_STR  = 4'b1000
	} mode_t;

	typedef enum logic [4:0] {
		PH_INT  = 5'b00001,
		PH_FRAC = 5'b00010,
		PH_EXP  = 5'b00100,
		PH_SIGN = 5'b01000,
		PH_EDIG = 5'b10000
	} phase_t;

	typedef struct packed {
		mode_t      mode;
		phase_t     phase;
		logic [7:0] quote;
	} state_t;

	typedef struct packed {
		logic skip_ws;
		logic str_mode;
		logic num_mode;
	} cfg_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       kept;
		logic       start;
		logic [1:0] kind;
		logic       err;
		logic       unclosed;
		logic       last;
	} result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_quote(input logic [7:0] c);
		return (c == CH_SQUOTE) || (c == CH_DQUOTE);
	endfunction

endpackage
`default_nettype wire

FILE: src/char_stream_tokenizer.sv
// Character stream tokenizer top level: APB registers, token state and result register.
// A result appears in out_valid in the cycle after its item is accepted.
// Throughput: one item per cycle; in_ready stays high while the result register
// is empty or being drained in the same cycle.
// Reset: token state returns to idle, integer phase, open quote zero; all mode
// registers clear; the result register is empty.
`default_nettype none
module char_stream_tokenizer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cst_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [cst_pkg::DATA_W-1:0]    pwdata,
	output logic      [cst_pkg::DATA_W-1:0]    prdata,
	output logic                               pready,

	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    in_char,
	input  wire logic                          in_last,

	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [7:0]                    out_char,
	output logic                               kept,
	output logic                               token_start,
	output logic      [1:0]                    token_kind,
	output logic                               format_error,
	output logic                               string_unclosed,
	output logic                               out_last
);

	cst_pkg::cfg_t    cfg_q;
	cst_pkg::state_t  state_q;
	cst_pkg::state_t  state_nxt;
	cst_pkg::result_t res;
	cst_pkg::result_t res_q;
	logic             out_valid_q;
	logic             in_fire;
	logic             wr_en;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				cst_pkg::REG_SKIP_WS:  cfg_q.skip_ws  <= pwdata[0];
				cst_pkg::REG_STR_MODE: cfg_q.str_mode <= pwdata[0];
				cst_pkg::REG_NUM_MODE: cfg_q.num_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			cst_pkg::REG_SKIP_WS:  prdata[0] = cfg_q.skip_ws;
			cst_pkg::REG_STR_MODE: prdata[0] = cfg_q.str_mode;
			cst_pkg::REG_NUM_MODE: prdata[0] = cfg_q.num_mode;
			default:               prdata    = '0;
		endcase
	end

	cst_classify u_classify (
		.ch   (in_char),
		.last (in_last),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode  <= cst_pkg::MODE_IDLE;
			state_q.phase <= cst_pkg::PH_INT;
			state_q.quote <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) res_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign out_char        = res_q.ch;
	assign kept            = res_q.kept;
	assign token_start     = res_q.start;
	assign token_kind      = res_q.kind;
	assign format_error    = res_q.err;
	assign string_unclosed = res_q.unclosed;
	assign out_last        = res_q.last;

	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kept) |-> (!token_start && token_kind == cst_pkg::KIND_WORD))
		else $error("skipped whitespace carries token marks");

	a_unclosed_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && string_unclosed) |-> (out_last && token_kind == cst_pkg::KIND_STR))
		else $error("unclosed string flagged off a last string char");

	a_err_not_num: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && format_error) |-> (token_kind != cst_pkg::KIND_NUM))
		else $error("format error on a number char");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_last) |=> (state_q.mode == cst_pkg::MODE_IDLE
			&& state_q.phase == cst_pkg::PH_INT))
		else $error("state not idle after last item");

	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_valid_q)
		else $error("accepted item produced no result");

endmodule
`default_nettype wire

FILE: src/cst_classify.sv
// Per-character classification and next-state logic of the tokenizer.
`default_nettype none
module cst_classify (
	input  wire logic            [7:0] ch,
	input  wire logic                  last,
	input  wire cst_pkg::cfg_t         cfg,
	input  wire cst_pkg::state_t       cur,
	output cst_pkg::state_t            nxt,
	output cst_pkg::result_t           res
);

	logic cont;
	logic dig;

	always_comb begin
		nxt          = cur;
		res.ch       = ch;
		res.kept     = 1'b1;
		res.start    = 1'b0;
		res.kind     = cst_pkg::KIND_WORD;
		res.err      = 1'b0;
		res.unclosed = 1'b0;
		res.last     = last;
		cont         = 1'b0;
		dig          = cst_pkg::is_digit(ch);

		unique case (cur.mode)
			cst_pkg::MODE_STR: begin
				res.kind = cst_pkg::KIND_STR;
				cont     = 1'b1;
				if (ch == cur.quote) nxt.mode = cst_pkg::MODE_IDLE;
			end
			cst_pkg::MODE_WORD: begin
				if (cst_pkg::is_alnum(ch)) begin
					res.kind = cst_pkg::KIND_WORD;
					cont     = 1'b1;
				end
			end
			cst_pkg::MODE_NUM: begin
				unique case (cur.phase)
					cst_pkg::PH_INT: begin
						if (ch == cst_pkg::CH_DOT) begin
							nxt.phase = cst_pkg::PH_FRAC;
							cont      = 1'b1;
						end else if (ch == cst_pkg::CH_EXP) begin
							nxt.phase = cst_pkg::PH_EXP;
							cont      = 1'b1;
						end else if (dig) begin
							cont = 1'b1;
						end
					end
					cst_pkg::PH_FRAC: begin
						if (ch == cst_pkg::CH_EXP) begin
							nxt.phase = cst_pkg::PH_EXP;
							cont      = 1'b1;
						end else if (dig) begin
							cont = 1'b1;
						end
					end
					cst_pkg::PH_EXP: begin
						if ((ch == cst_pkg::CH_PLUS) || (ch == cst_pkg::CH_MINUS)) begin
							nxt.phase = cst_pkg::PH_SIGN;
							cont      = 1'b1;
						end else if (dig) begin
							nxt.phase = cst_pkg::PH_EDIG;
							cont      = 1'b1;
						end else begin
							res.err = 1'b1;
						end
					end
					cst_pkg::PH_SIGN: begin
						if (dig) begin
							nxt.phase = cst_pkg::PH_EDIG;
							cont      = 1'b1;
						end else begin
							res.err = 1'b1;
						end
					end
					cst_pkg::PH_EDIG: begin
						cont = dig;
					end
					default: begin
						cont = 1'b0;
					end
				endcase
				if (cont) res.kind = cst_pkg::KIND_NUM;
			end
			default: begin
				cont = 1'b0;
			end
		endcase

		// fresh token start, or skipped whitespace
		if (!cont) begin
			nxt.mode = cst_pkg::MODE_IDLE;
			if (cfg.skip_ws && cst_pkg::is_space(ch)) begin
				res.kept  = 1'b0;
				res.start = 1'b0;
				res.kind  = cst_pkg::KIND_WORD;
			end else begin
				res.start = 1'b1;
				priority if (cfg.str_mode && cst_pkg::is_quote(ch)) begin
					nxt.mode  = cst_pkg::MODE_STR;
					nxt.quote = ch;
					res.kind  = cst_pkg::KIND_STR;
				end else if (cfg.num_mode && dig) begin
					nxt.mode  = cst_pkg::MODE_NUM;
					nxt.phase = cst_pkg::PH_INT;
					res.kind  = cst_pkg::KIND_NUM;
				end else if (cst_pkg::is_alnum(ch)) begin
					nxt.mode = cst_pkg::MODE_WORD;
					res.kind = cst_pkg::KIND_WORD;
				end else begin
					res.kind = cst_pkg::KIND_CHAR;
				end
			end
		end

		if (last) begin
			res.unclosed = (nxt.mode == cst_pkg::MODE_STR);
			nxt.mode     = cst_pkg::MODE_IDLE;
			nxt.phase    = cst_pkg::PH_INT;
		end
	end

endmodule
`default_nettype wire
